/* src/touch_baseline_hysteresis_detector_defines.svh */
// ---------------------------------------------------------------------------
// touch baseline hysteresis detector assertion macros
// concurrent checks on a clock and an active-low reset, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef TOUCH_BASELINE_HYSTERESIS_DETECTOR_DEFINES_SVH
`define TOUCH_BASELINE_HYSTERESIS_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TBHD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define TBHD_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define TBHD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define TBHD_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* src/tbhd_pkg.sv */
// ---------------------------------------------------------------------------
// tbhd_pkg
// widths, register indexes, reset values and shared types of the detector
// ---------------------------------------------------------------------------
package tbhd_pkg;

	localparam int ADC_BITS      = 10;
	localparam int CNT_BITS      = 8;
	localparam int SUM_BITS      = ADC_BITS + CNT_BITS;
	localparam int THR_BITS      = 10;
	localparam int SHIFT_BITS    = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 10;
	localparam int DIV_STEP_BITS = $clog2(SUM_BITS);
	localparam int DELTA_BITS    = ADC_BITS + 1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ON_THRESHOLD  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFF_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_SHIFT    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRESSED_SHIFT = 3'd4;

	// register reset values
	localparam logic [CNT_BITS-1:0]   RST_SAMPLE_COUNT  = 8'd8;
	localparam logic [THR_BITS-1:0]   RST_ON_THRESHOLD  = 10'd40;
	localparam logic [THR_BITS-1:0]   RST_OFF_THRESHOLD = 10'd20;
	localparam logic [SHIFT_BITS-1:0] RST_IDLE_SHIFT    = 4'd4;
	localparam logic [SHIFT_BITS-1:0] RST_PRESSED_SHIFT = 4'd6;

	typedef logic [ADC_BITS-1:0]          level_t;
	typedef logic signed [ADC_BITS+1:0]   wide_delta_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tbhd_div_stat_t;

	typedef struct packed {
		logic                  pressed;
		level_t                baseline;
		logic [DELTA_BITS-1:0] delta;
	} tbhd_trk_res_t;

endpackage

/* src/tbhd_div.sv */
// ---------------------------------------------------------------------------
// tbhd_div
// restoring divider, one quotient bit per cycle through one subtractor
// ---------------------------------------------------------------------------
module tbhd_div
	import tbhd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_BITS-1:0] dividend,
	input  logic [CNT_BITS-1:0] divisor,
	output tbhd_div_stat_t      stat,
	output logic [SUM_BITS-1:0] quotient
);

	logic [SUM_BITS-1:0]      acc_q;
	logic [CNT_BITS-1:0]      rem_q;
	logic [CNT_BITS-1:0]      dvs_q;
	logic [DIV_STEP_BITS-1:0] step_q;
	logic                     busy_q;
	logic                     done_q;

	logic [CNT_BITS:0]   rem_sh;
	logic [CNT_BITS+1:0] diff;
	logic                ge;

	// shared subtract and compare
	assign rem_sh = {rem_q, acc_q[SUM_BITS-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[CNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_STEP_BITS'(SUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[SUM_BITS-2:0], ge};
			rem_q <= ge ? diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = acc_q;

endmodule

/* src/tbhd_track.sv */
// ---------------------------------------------------------------------------
// tbhd_track
// baseline tracking and press hysteresis, state moves once per average
// ---------------------------------------------------------------------------
module tbhd_track
	import tbhd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  update,
	input  level_t                avg,
	input  logic [THR_BITS-1:0]   on_thr,
	input  logic [THR_BITS-1:0]   off_thr,
	input  logic [SHIFT_BITS-1:0] idle_shift,
	input  logic [SHIFT_BITS-1:0] pressed_shift,
	output tbhd_trk_res_t         res
);

	level_t base_q;
	logic   loaded_q;
	logic   pressed_q;

	wide_delta_t delta_cur;
	wide_delta_t drift;
	wide_delta_t drift_sh;
	wide_delta_t base_drift;
	wide_delta_t delta_nx;
	logic [SHIFT_BITS-1:0] shamt;
	level_t base_nx;
	logic   pressed_nx;

	assign delta_cur  = wide_delta_t'(base_q) - wide_delta_t'(avg);
	assign drift      = wide_delta_t'(avg) - wide_delta_t'(base_q);
	assign shamt      = pressed_q ? pressed_shift : idle_shift;
	assign drift_sh   = drift >>> shamt;
	assign base_drift = wide_delta_t'(base_q) + drift_sh;

	always_comb begin
		base_nx    = base_q;
		pressed_nx = pressed_q;
		if (!loaded_q) begin
			// first average only loads the baseline
			base_nx    = avg;
			pressed_nx = 1'b0;
		end else if (!pressed_q) begin
			if (delta_cur >= wide_delta_t'(on_thr))
				pressed_nx = 1'b1;
			else
				base_nx = base_drift[ADC_BITS-1:0];
		end else begin
			if (delta_cur <= wide_delta_t'(off_thr))
				pressed_nx = 1'b0;
			base_nx = base_drift[ADC_BITS-1:0];
		end
	end

	assign delta_nx = wide_delta_t'(base_nx) - wide_delta_t'(avg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			loaded_q  <= 1'b0;
			pressed_q <= 1'b0;
		end else if (update) begin
			base_q    <= base_nx;
			loaded_q  <= 1'b1;
			pressed_q <= pressed_nx;
		end
	end

	assign res.pressed  = pressed_nx;
	assign res.baseline = base_nx;
	assign res.delta    = delta_nx[DELTA_BITS-1:0];

endmodule

/* src/touch_baseline_hysteresis_detector.sv */
// ---------------------------------------------------------------------------
// touch_baseline_hysteresis_detector
// sample averaging, shared iterative divide, baseline tracking and hysteresis
// ---------------------------------------------------------------------------
// Each input beat is one ADC reading; readings are summed until
// sample_count of them are in (a count of zero acts as one).
// The beat that completes an average starts the shared restoring divider,
// which makes one quotient bit per cycle: in_ready then stays low while it
// divides and until the result is loaded into the output register, which
// waits while a previous result is still held with out_ready low. Each
// average gives one output beat with pressed, average, baseline and delta.
// Configuration writes are taken in any cycle.
// ---------------------------------------------------------------------------
`include "touch_baseline_hysteresis_detector_defines.svh"

module touch_baseline_hysteresis_detector
	import tbhd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ADC_BITS-1:0]      sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     pressed,
	output logic [ADC_BITS-1:0]      average,
	output logic [ADC_BITS-1:0]      baseline,
	output logic signed [DELTA_BITS-1:0] delta,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t state_q;

	logic [CNT_BITS-1:0]   sample_count_q;
	logic [THR_BITS-1:0]   on_thr_q;
	logic [THR_BITS-1:0]   off_thr_q;
	logic [SHIFT_BITS-1:0] idle_shift_q;
	logic [SHIFT_BITS-1:0] pressed_shift_q;

	logic [SUM_BITS-1:0] sum_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                pressed_q;
	level_t              average_q;
	level_t              baseline_q;
	logic [DELTA_BITS-1:0] delta_q;

	logic [CNT_BITS-1:0] count_eff;
	logic [SUM_BITS-1:0] sum_nx;
	logic [CNT_BITS-1:0] cnt_nx;
	logic                in_beat;
	logic                complete;
	logic                div_start;
	logic                hold_load;
	tbhd_div_stat_t      div_stat;
	logic [SUM_BITS-1:0] quotient;
	level_t              avg;
	tbhd_trk_res_t       trk_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= RST_SAMPLE_COUNT;
			on_thr_q        <= RST_ON_THRESHOLD;
			off_thr_q       <= RST_OFF_THRESHOLD;
			idle_shift_q    <= RST_IDLE_SHIFT;
			pressed_shift_q <= RST_PRESSED_SHIFT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT:  sample_count_q  <= cfg_data[CNT_BITS-1:0];
				REG_ON_THRESHOLD:  on_thr_q        <= cfg_data[THR_BITS-1:0];
				REG_OFF_THRESHOLD: off_thr_q       <= cfg_data[THR_BITS-1:0];
				REG_IDLE_SHIFT:    idle_shift_q    <= cfg_data[SHIFT_BITS-1:0];
				REG_PRESSED_SHIFT: pressed_shift_q <= cfg_data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign count_eff = (sample_count_q == '0) ? CNT_BITS'(1) : sample_count_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign sum_nx    = sum_q + SUM_BITS'(sample);
	assign cnt_nx    = cnt_q + 1'b1;
	// counter wrap also ends an average
	assign complete  = (cnt_nx == '0) || (cnt_nx >= count_eff);
	assign div_start = in_beat && complete;
	assign hold_load = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	assign avg       = quotient[ADC_BITS-1:0];

	tbhd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nx),
		.divisor  (count_eff),
		.stat     (div_stat),
		.quotient (quotient)
	);

	tbhd_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.update        (hold_load),
		.avg           (avg),
		.on_thr        (on_thr_q),
		.off_thr       (off_thr_q),
		.idle_shift    (idle_shift_q),
		.pressed_shift (pressed_shift_q),
		.res           (trk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !hold_load)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (complete) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							sum_q <= sum_nx;
							cnt_q <= cnt_nx;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (hold_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			pressed_q  <= trk_res.pressed;
			average_q  <= avg;
			baseline_q <= trk_res.baseline;
			delta_q    <= trk_res.delta;
		end
	end

	assign out_valid = out_valid_q;
	assign pressed   = pressed_q;
	assign average   = average_q;
	assign baseline  = baseline_q;
	assign delta     = delta_q;

	`TBHD_ASSERT_IMP(a_done_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV, "divider done outside divide state")
	`TBHD_ASSERT_IMP(a_ready_div_idle, clk, arst_n, in_ready, !div_stat.busy && !div_stat.done, "input ready while divider works")
	`TBHD_ASSERT_NXT(a_start_busy, clk, arst_n, div_start, div_stat.busy && state_q == ST_DIV, "completed average did not start divider")
	`TBHD_ASSERT_NXT(a_load_out, clk, arst_n, hold_load, out_valid && state_q == ST_IDLE, "result load did not raise out_valid")

endmodule

/* sim/tb_touch_baseline_hysteresis_detector.sv */
// ---------------------------------------------------------------------------
// tb_touch_baseline_hysteresis_detector
// ---------------------------------------------------------------------------
// Drives ADC readings into the detector and programs its registers through
// the config channel. An independent predictor tracks the averaging,
// baseline drift and the press/release hysteresis, and every output beat is
// checked field by field against it. A short directed part covers
// the first average, both threshold boundaries, extreme settings, a zero
// count, a count lowered mid-average and writes to unused indexes. Random
// press and release episodes follow, under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_touch_baseline_hysteresis_detector;
	import tbhd_pkg::*;

	localparam int     HALF_PERIOD   = 10;
	localparam int     RESET_CYCLES  = 7;
	localparam int     ITEM_GOAL     = 1950;
	localparam int     IDLE_PCT      = 16;
	localparam int     SETTLE_CYCLES = SUM_BITS + 6;
	localparam int     STALL_LIMIT   = 5000;
	localparam int     LEVEL_TOP     = (1 << ADC_BITS) - 1;
	localparam int     THR_TOP       = (1 << THR_BITS) - 1;
	localparam int     SHIFT_TOP     = (1 << SHIFT_BITS) - 1;
	localparam int     CNT_TOP       = (1 << CNT_BITS) - 1;
	localparam int     BIG_PHASE     = 5;
	localparam int     STEADY_PHASE  = 2;

	// indexes past the last register, ignored by the block
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic                         pressed;
		level_t                       average;
		level_t                       baseline;
		logic signed [DELTA_BITS-1:0] delta;
	} touch_update_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [ADC_BITS-1:0]          sample;
	logic                         out_valid;
	logic                         out_ready;
	logic                         pressed;
	logic [ADC_BITS-1:0]          average;
	logic [ADC_BITS-1:0]          baseline;
	logic signed [DELTA_BITS-1:0] delta;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_BITS-1:0]      cfg_index;
	logic [CFG_DATA_BITS-1:0]     cfg_data;

	touch_baseline_hysteresis_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pressed   (pressed),
		.average   (average),
		.baseline  (baseline),
		.delta     (delta),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// registers and state of the detector as the predictor sees them
	logic [CNT_BITS-1:0]   count_reg         = RST_SAMPLE_COUNT;
	logic [THR_BITS-1:0]   on_reg            = RST_ON_THRESHOLD;
	logic [THR_BITS-1:0]   off_reg           = RST_OFF_THRESHOLD;
	logic [SHIFT_BITS-1:0] idle_shift_reg    = RST_IDLE_SHIFT;
	logic [SHIFT_BITS-1:0] pressed_shift_reg = RST_PRESSED_SHIFT;
	int unsigned           sum_acc           = 0;
	logic [CNT_BITS-1:0]   reading_cnt       = '0;
	level_t                base_level        = '0;
	bit                    base_loaded       = 1'b0;
	bit                    touched           = 1'b0;

	touch_update_t pending_updates[$];

	int mismatches      = 0;
	int readings_sent   = 0;
	int updates_checked = 0;
	int presses_seen    = 0;
	int reg_writes      = 0;
	int stall_cycles    = 0;
	bit steady          = 1'b0;

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	function automatic level_t drift_toward(level_t from, level_t target,
			logic [SHIFT_BITS-1:0] sh);
		int step;
		// arithmetic shift, rounds toward minus infinity
		step = (int'(target) - int'(from)) >>> sh;
		return level_t'(int'(from) + step);
	endfunction

	function automatic void take_reading(level_t value);
		int unsigned   span;
		level_t        mean;
		int            gap;
		touch_update_t upd;
		span = (count_reg == 0) ? 1 : count_reg;
		sum_acc += value;
		reading_cnt = reading_cnt + 1'b1;
		if (reading_cnt != 0 && reading_cnt < span)
			return;
		mean = level_t'(sum_acc / span);
		sum_acc = 0;
		reading_cnt = '0;
		if (!base_loaded) begin
			base_level = mean;
			base_loaded = 1'b1;
		end else begin
			gap = int'(base_level) - int'(mean);
			if (!touched) begin
				if (gap >= int'(on_reg))
					touched = 1'b1;
				else
					base_level = drift_toward(base_level, mean, idle_shift_reg);
			end else begin
				if (gap <= int'(off_reg))
					touched = 1'b0;
				base_level = drift_toward(base_level, mean, pressed_shift_reg);
			end
		end
		upd.pressed = touched;
		upd.average = mean;
		upd.baseline = base_level;
		upd.delta = DELTA_BITS'(int'(base_level) - int'(mean));
		pending_updates.push_back(upd);
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] data);
		case (idx)
		REG_SAMPLE_COUNT:  count_reg = data[CNT_BITS-1:0];
		REG_ON_THRESHOLD:  on_reg = data[THR_BITS-1:0];
		REG_OFF_THRESHOLD: off_reg = data[THR_BITS-1:0];
		REG_IDLE_SHIFT:    idle_shift_reg = data[SHIFT_BITS-1:0];
		REG_PRESSED_SHIFT: pressed_shift_reg = data[SHIFT_BITS-1:0];
		default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want_val,
			logic signed [31:0] got_val);
		if (got_val !== want_val) begin
			$error("%s: expected %0d, got %0d", name, want_val, got_val);
			mismatches++;
		end
	endfunction

	// result checking, prediction on accepted beats and the stall watchdog
	always @(posedge clk) begin
		touch_update_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_updates.size() == 0) begin
					$error("result beat with nothing expected: average %0d", average);
					mismatches++;
				end else begin
					want = pending_updates.pop_front();
					updates_checked++;
					if (want.pressed)
						presses_seen++;
					check_field("pressed", want.pressed, pressed);
					check_field("average", want.average, average);
					check_field("baseline", want.baseline, baseline);
					check_field("delta", want.delta, delta);
				end
			end
			if (in_valid && in_ready)
				take_reading(sample);
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_reading(input level_t value);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = value;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		readings_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	// drop valid, drain all expected updates and let the divider finish
	task automatic settle();
		in_valid = 1'b0;
		while (pending_updates.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_average(input int center, input int spread);
		int n;
		int v;
		n = (count_reg == 0) ? 1 : count_reg;
		repeat (n) begin
			v = center + int'($urandom_range(2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > LEVEL_TOP)
				v = LEVEL_TOP;
			send_reading(level_t'(v));
		end
	endtask

	task automatic touch_episode(input int rest_level, input int spread);
		int depth;
		if ($urandom_range(1))
			depth = int'(on_reg) + int'($urandom_range(40)) - 20;
		else
			depth = $urandom_range(500);
		repeat ($urandom_range(4, 1)) send_average(rest_level, spread);
		repeat ($urandom_range(5, 1)) send_average(rest_level - depth, spread);
		repeat ($urandom_range(4, 1)) send_average(rest_level, spread);
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] pick_shift();
		logic [SHIFT_BITS-1:0] sh;
		case ($urandom_range(5))
		0: sh = '0;
		1: sh = SHIFT_BITS'(SHIFT_TOP);
		default: sh = SHIFT_BITS'($urandom_range(SHIFT_TOP));
		endcase
		// upper data bits are dropped by the block
		return {(CFG_DATA_BITS - SHIFT_BITS)'($urandom), sh};
	endfunction

	task automatic randomize_regs(input int phase);
		logic [CNT_BITS-1:0] cnt;
		int                  on_thr;
		int                  off_thr;
		case ($urandom_range(9))
		0: cnt = '0;
		default: cnt = CNT_BITS'($urandom_range(8, 1));
		endcase
		if (phase == BIG_PHASE)
			cnt = CNT_BITS'(CNT_TOP);
		case ($urandom_range(9))
		0: on_thr = 0;
		1: on_thr = THR_TOP;
		default: on_thr = $urandom_range(150, 5);
		endcase
		case ($urandom_range(9))
		0: off_thr = 0;
		1: off_thr = THR_TOP;
		default: off_thr = $urandom_range(on_thr);
		endcase
		write_reg(REG_SAMPLE_COUNT, {(CFG_DATA_BITS - CNT_BITS)'($urandom), cnt});
		write_reg(REG_ON_THRESHOLD, CFG_DATA_BITS'(on_thr));
		write_reg(REG_OFF_THRESHOLD, CFG_DATA_BITS'(off_thr));
		write_reg(REG_IDLE_SHIFT, pick_shift());
		write_reg(REG_PRESSED_SHIFT, pick_shift());
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_BITS'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
				CFG_DATA_BITS'($urandom));
	endtask

	// reset settings: eight readings of alternating extremes load the baseline
	task automatic test_first_average();
		repeat (4) begin
			send_reading(level_t'(LEVEL_TOP));
			send_reading('0);
		end
		settle();
	endtask

	// zero count acts as one; hits delta equal to both thresholds
	task automatic test_threshold_boundaries();
		write_reg(REG_SAMPLE_COUNT, '0);
		send_reading(10'd511);
		send_reading(10'd520);
		send_reading(10'd471);
		send_reading(10'd480);
		send_reading(10'd490);
		settle();
	endtask

	task automatic test_extreme_settings();
		write_reg(REG_SAMPLE_COUNT, CFG_DATA_BITS'(1));
		write_reg(REG_ON_THRESHOLD, '0);
		write_reg(REG_OFF_THRESHOLD, CFG_DATA_BITS'(THR_TOP));
		write_reg(REG_IDLE_SHIFT, '0);
		write_reg(REG_PRESSED_SHIFT, CFG_DATA_BITS'(SHIFT_TOP));
		send_reading(level_t'(LEVEL_TOP));
		send_reading('0);
		send_reading(level_t'(LEVEL_TOP));
		send_reading('0);
		send_reading(10'd1000);
		settle();
		write_reg(REG_ON_THRESHOLD, CFG_DATA_BITS'(THR_TOP));
		write_reg(REG_OFF_THRESHOLD, '0);
		send_reading('0);
		settle();
		// baseline at zero, full-scale reading gives the most negative delta
		write_reg(REG_IDLE_SHIFT, CFG_DATA_BITS'(SHIFT_TOP));
		send_reading(level_t'(LEVEL_TOP));
		settle();
	endtask

	task automatic test_count_lowered();
		write_reg(REG_SAMPLE_COUNT, CFG_DATA_BITS'(4));
		repeat (3) send_reading(level_t'($urandom_range(LEVEL_TOP)));
		settle();
		write_reg(REG_SAMPLE_COUNT, CFG_DATA_BITS'(2));
		send_reading(level_t'($urandom_range(LEVEL_TOP)));
		settle();
	endtask

	task automatic test_spare_index();
		write_reg(REG_SPARE_FIRST, '0);
		write_reg(REG_SPARE_LAST, CFG_DATA_BITS'(THR_TOP));
		send_reading(10'd300);
		send_reading(10'd700);
		settle();
	endtask

	task automatic test_random_touches();
		int phase;
		int rest;
		int spread;
		phase = 0;
		while (readings_sent < ITEM_GOAL) begin
			settle();
			steady = (phase == STEADY_PHASE);
			randomize_regs(phase);
			rest = $urandom_range(900, 150);
			spread = $urandom_range(12);
			if (phase == BIG_PHASE) begin
				send_average(LEVEL_TOP, 2);
				send_average(rest, spread);
			end else begin
				repeat ($urandom_range(6, 2)) begin
					if ($urandom_range(9) == 0)
						send_average(LEVEL_TOP / 2, LEVEL_TOP / 2 + 1);
					else
						touch_episode(rest, spread);
				end
			end
			// leave a partial average behind for the next settings
			repeat ($urandom_range(3)) send_reading(level_t'($urandom_range(LEVEL_TOP)));
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SAMPLE_COUNT;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_first_average();
		test_threshold_boundaries();
		test_extreme_settings();
		test_count_lowered();
		test_spare_index();
		test_random_touches();
		settle();

		$display("run covered %0d readings, %0d updates checked (%0d pressed), %0d reg writes",
			readings_sent, updates_checked, presses_seen, reg_writes);
		if (mismatches == 0 && pending_updates.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
